@@ src/mls_pkg.sv @@
package mls_pkg;

   // Field widths
   localparam int OPCODE_W = 2;
   localparam int LFLAGS_W = 6;
   localparam int XFLAGS_W = 4;
   localparam int ALERT_W  = 3;
   localparam int LIMIT_W  = 16;
   localparam int RCOUNT_W = 8;
   localparam int FLAGS_W  = LFLAGS_W + XFLAGS_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_STATUS   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_HEADED   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_UNHEADED = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_TICK     = 2'd3;

   // Alert codes
   localparam logic [ALERT_W-1:0] ALERT_NONE       = 3'd0;
   localparam logic [ALERT_W-1:0] ALERT_SPEED      = 3'd1;
   localparam logic [ALERT_W-1:0] ALERT_WEEK       = 3'd2;
   localparam logic [ALERT_W-1:0] ALERT_DAY        = 3'd3;
   localparam logic [ALERT_W-1:0] ALERT_CONTINUOUS = 3'd4;
   localparam logic [ALERT_W-1:0] ALERT_MOVING_OUT = 3'd5;

   // Alert flag bit positions (link flags low, extra flags high)
   localparam int FLAG_FIX        = 0;
   localparam int FLAG_SPEED      = 4;
   localparam int FLAG_CONTINUOUS = 5;
   localparam int FLAG_DAY        = 6;
   localparam int FLAG_WEEK       = 7;
   localparam int FLAG_MOVING_OUT = 9;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_READY_IDLE_LIMIT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVERY_FIRST_LIMIT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVERY_LATER_LIMIT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CRASH_RESET_COUNT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STALE_LIMIT          = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_FIX_LIMIT         = 3'd5;

   // Register reset values
   localparam logic [LIMIT_W-1:0]  RST_READY_IDLE_LIMIT     = 16'd120;
   localparam logic [LIMIT_W-1:0]  RST_RECOVERY_FIRST_LIMIT = 16'd180;
   localparam logic [LIMIT_W-1:0]  RST_RECOVERY_LATER_LIMIT = 16'd900;
   localparam logic [RCOUNT_W-1:0] RST_CRASH_RESET_COUNT    = 8'd5;
   localparam logic [LIMIT_W-1:0]  RST_STALE_LIMIT          = 16'd10;
   localparam logic [LIMIT_W-1:0]  RST_NO_FIX_LIMIT         = 16'd300;

   localparam logic [LIMIT_W-1:0]  LIMIT_MAX  = '1;
   localparam logic [RCOUNT_W-1:0] RCOUNT_MAX = '1;

   typedef struct packed {
      logic [LIMIT_W-1:0]  ready_idle_limit;
      logic [LIMIT_W-1:0]  recovery_first_limit;
      logic [LIMIT_W-1:0]  recovery_later_limit;
      logic [RCOUNT_W-1:0] crash_reset_count;
      logic [LIMIT_W-1:0]  stale_limit;
      logic [LIMIT_W-1:0]  no_fix_limit;
   } cfg_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [LFLAGS_W-1:0] link_flags;
      logic [XFLAGS_W-1:0] extra_flags;
      logic                extra_valid;
      logic                low_power;
   } item_type;

   typedef struct packed {
      logic                modem_reset;
      logic                crashed;
      logic [ALERT_W-1:0]  alert_code;
      logic                power_off;
      logic [RCOUNT_W-1:0] reset_total;
   } result_type;

   typedef struct packed {
      logic [LIMIT_W-1:0]  idle_count;
      logic [RCOUNT_W-1:0] reset_count;
      logic                link_ready;
      logic                link_crashed;
      logic                slow_recovery;
      logic [FLAGS_W-1:0]  alert_flags;
      logic [LIMIT_W-1:0]  no_fix_count;
   } state_type;

endpackage

@@ src/mls_if.sv @@
interface mls_req_if;
   logic                          valid;
   logic                          ready;
   logic [mls_pkg::OPCODE_W-1:0]  opcode;
   logic [mls_pkg::LFLAGS_W-1:0]  link_flags;
   logic [mls_pkg::XFLAGS_W-1:0]  extra_flags;
   logic                          extra_valid;
   logic                          low_power;

   modport source (output valid, opcode, link_flags, extra_flags, extra_valid, low_power,
                   input ready);
   modport sink   (input valid, opcode, link_flags, extra_flags, extra_valid, low_power,
                   output ready);
endinterface

interface mls_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          modem_reset;
   logic                          crashed;
   logic [mls_pkg::ALERT_W-1:0]   alert_code;
   logic                          power_off;
   logic [mls_pkg::RCOUNT_W-1:0]  reset_total;

   modport source (output valid, modem_reset, crashed, alert_code, power_off, reset_total,
                   input ready);
   modport sink   (input valid, modem_reset, crashed, alert_code, power_off, reset_total,
                   output ready);
endinterface

@@ src/mls_csr.sv @@
module mls_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [mls_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mls_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output mls_pkg::cfg_type                  cfg
);

   mls_pkg::cfg_type cfg_ff;
   mls_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            mls_pkg::CSR_READY_IDLE_LIMIT:     cfg_in.ready_idle_limit     = csr_wdata;
            mls_pkg::CSR_RECOVERY_FIRST_LIMIT: cfg_in.recovery_first_limit = csr_wdata;
            mls_pkg::CSR_RECOVERY_LATER_LIMIT: cfg_in.recovery_later_limit = csr_wdata;
            mls_pkg::CSR_CRASH_RESET_COUNT:
               cfg_in.crash_reset_count = csr_wdata[mls_pkg::RCOUNT_W-1:0];
            mls_pkg::CSR_STALE_LIMIT:          cfg_in.stale_limit          = csr_wdata;
            mls_pkg::CSR_NO_FIX_LIMIT:         cfg_in.no_fix_limit         = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ready_idle_limit     <= mls_pkg::RST_READY_IDLE_LIMIT;
         cfg_ff.recovery_first_limit <= mls_pkg::RST_RECOVERY_FIRST_LIMIT;
         cfg_ff.recovery_later_limit <= mls_pkg::RST_RECOVERY_LATER_LIMIT;
         cfg_ff.crash_reset_count    <= mls_pkg::RST_CRASH_RESET_COUNT;
         cfg_ff.stale_limit          <= mls_pkg::RST_STALE_LIMIT;
         cfg_ff.no_fix_limit         <= mls_pkg::RST_NO_FIX_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/mls_eval.sv @@
module mls_eval (
   input  mls_pkg::cfg_type     cfg,
   input  mls_pkg::state_type   state,
   input  mls_pkg::item_type    item,
   output mls_pkg::state_type   state_next,
   output mls_pkg::result_type  result
);

   always_comb begin
      logic [mls_pkg::LIMIT_W-1:0] limit;
      logic                        healthy;
      mls_pkg::state_type          s;
      mls_pkg::result_type         r;

      s       = state;
      r       = '0;
      healthy = !state.link_crashed && state.link_ready;
      limit   = healthy ? cfg.ready_idle_limit
              : (state.slow_recovery ? cfg.recovery_later_limit : cfg.recovery_first_limit);

      if (item.opcode != mls_pkg::OP_TICK) begin
         s.idle_count = '0;
         if (item.opcode == mls_pkg::OP_STATUS) begin
            s.alert_flags[mls_pkg::LFLAGS_W-1:0] = item.link_flags;
            if (item.extra_valid) begin
               s.alert_flags[mls_pkg::FLAGS_W-1:mls_pkg::LFLAGS_W] = item.extra_flags;
            end
         end
         if (item.opcode == mls_pkg::OP_STATUS || item.opcode == mls_pkg::OP_HEADED) begin
            s.link_ready   = 1'b1;
            s.link_crashed = 1'b0;
         end
      end else begin
         if (state.idle_count != mls_pkg::LIMIT_MAX) begin
            s.idle_count = state.idle_count + 1'b1;
         end
         if (s.idle_count >= limit) begin
            s.idle_count  = '0;
            r.modem_reset = 1'b1;
            s.alert_flags = '0;
            if (state.reset_count != mls_pkg::RCOUNT_MAX) begin
               s.reset_count = state.reset_count + 1'b1;
            end
            if (healthy) begin
               if (s.reset_count > cfg.crash_reset_count) begin
                  s.link_crashed = 1'b1;
               end
            end else begin
               s.slow_recovery = 1'b1;
            end
         end
         if (s.idle_count > cfg.stale_limit) begin
            s.alert_flags = '0;
         end
      end

      // Alert priority applies only with a position fix
      if (s.alert_flags[mls_pkg::FLAG_FIX]) begin
         if (s.alert_flags[mls_pkg::FLAG_SPEED])           r.alert_code = mls_pkg::ALERT_SPEED;
         else if (s.alert_flags[mls_pkg::FLAG_WEEK])       r.alert_code = mls_pkg::ALERT_WEEK;
         else if (s.alert_flags[mls_pkg::FLAG_DAY])        r.alert_code = mls_pkg::ALERT_DAY;
         else if (s.alert_flags[mls_pkg::FLAG_CONTINUOUS]) r.alert_code = mls_pkg::ALERT_CONTINUOUS;
         else if (s.alert_flags[mls_pkg::FLAG_MOVING_OUT]) r.alert_code = mls_pkg::ALERT_MOVING_OUT;
         else                                              r.alert_code = mls_pkg::ALERT_NONE;
         s.no_fix_count = '0;
      end else if (item.low_power) begin
         if (state.no_fix_count != mls_pkg::LIMIT_MAX) begin
            s.no_fix_count = state.no_fix_count + 1'b1;
         end
         if (s.no_fix_count >= cfg.no_fix_limit) begin
            s.no_fix_count = '0;
            r.power_off    = 1'b1;
         end
      end

      r.crashed     = s.link_crashed;
      r.reset_total = s.reset_count;
      state_next    = s;
      result        = r;
   end

endmodule

@@ src/modem_link_supervisor.sv @@
// Modem link supervisor. Takes one word per cycle on req_chan (frame events
// and one-second idle ticks) unless backpressure holds it, and returns exactly
// one result word per input word on rsp_chan, in order. A word is captured in
// an input register, then evaluated against the supervisor state and
// registered into the result register once that register is empty or being
// drained; sustained throughput is one word per cycle while rsp_chan does not
// stall; the single state update per word (idle, reset and no-fix counters,
// flags) sets that rate. Backpressure on rsp_chan stalls the result register,
// and the input register then holds one more word before req_chan.ready drops.
// Registers on the csr_ port may be written only while no word is in flight.
module modem_link_supervisor (
   input  logic                             clock,
   input  logic                             reset,
   mls_req_if.sink                          req_chan,
   mls_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [mls_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mls_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   mls_pkg::cfg_type    cfg;

   // Input stage
   logic                in_v_ff;
   logic                in_v_in;
   mls_pkg::item_type   in_ff;
   mls_pkg::item_type   req_item;

   // Supervisor state
   mls_pkg::state_type  state_ff;
   mls_pkg::state_type  state_in;

   // Result stage
   logic                out_v_ff;
   logic                out_v_in;
   mls_pkg::result_type out_ff;
   mls_pkg::result_type eval_result;

   logic                advance;
   logic                req_take;

   mls_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mls_eval u_eval (
      .cfg        (cfg),
      .state      (state_ff),
      .item       (in_ff),
      .state_next (state_in),
      .result     (eval_result)
   );

   // Word moves from input register to result register when the latter is
   // empty or being drained this cycle; the state commits on the same edge.
   assign advance  = in_v_ff && (!out_v_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !in_v_ff || advance;

   assign req_item.opcode      = req_chan.opcode;
   assign req_item.link_flags  = req_chan.link_flags;
   assign req_item.extra_flags = req_chan.extra_flags;
   assign req_item.extra_valid = req_chan.extra_valid;
   assign req_item.low_power   = req_chan.low_power;

   always_comb begin
      in_v_in = in_v_ff;
      if (req_take) begin
         in_v_in = 1'b1;
      end else if (advance) begin
         in_v_in = 1'b0;
      end
   end

   always_comb begin
      out_v_in = out_v_ff;
      if (advance) begin
         out_v_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         state_ff <= '0;
      end else begin
         in_v_ff  <= in_v_in;
         out_v_ff <= out_v_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= req_item;
      end
      if (advance) begin
         out_ff <= eval_result;
      end
   end

   assign rsp_chan.valid       = out_v_ff;
   assign rsp_chan.modem_reset = out_ff.modem_reset;
   assign rsp_chan.crashed     = out_ff.crashed;
   assign rsp_chan.alert_code  = out_ff.alert_code;
   assign rsp_chan.power_off   = out_ff.power_off;
   assign rsp_chan.reset_total = out_ff.reset_total;

   // A pending result can only report a reset if the count moved off zero
   a_reset_counted: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_ff.modem_reset |-> out_ff.reset_total != '0)
      else $error("modem reset reported with zero reset total");

   // Any frame clears the idle counter
   a_frame_clears_idle: assert property (@(posedge clock) disable iff (reset)
      advance && in_ff.opcode != mls_pkg::OP_TICK |=> state_ff.idle_count == '0)
      else $error("idle count not cleared by frame");

   // Power-off only in power-save mode
   a_power_off_psave: assert property (@(posedge clock) disable iff (reset)
      advance && eval_result.power_off |-> in_ff.low_power)
      else $error("power-off outside power save");

   // An alert is only shown while the stored flags carry a fix
   a_alert_needs_fix: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_ff.alert_code != mls_pkg::ALERT_NONE
         |-> state_ff.alert_flags[mls_pkg::FLAG_FIX])
      else $error("alert code without position fix");

   // A full input stage that cannot move must not take another word
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      in_v_ff && !advance |-> !req_chan.ready)
      else $error("input stage overrun");

endmodule

@@ sim/tb_modem_link_supervisor.sv @@
`timescale 1ns / 1ps

module tb_modem_link_supervisor;

   localparam int HOLD_CYCLES = 64;       // long receiver hold-off
   localparam int MAX_PRINTS  = 40;

   logic clock;
   logic reset;
   logic csr_we;
   logic [mls_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [mls_pkg::CSR_DATA_W-1:0] csr_wdata;

   mls_req_if req_chan ();
   mls_rsp_if rsp_chan ();

   modem_link_supervisor u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Supervisor state as the testbench sees it, plus the live register set
   // ---------------------------------------------------------------------
   mls_pkg::cfg_type              cfg_now;
   logic [mls_pkg::LIMIT_W-1:0]   idle_ticks;
   logic [mls_pkg::RCOUNT_W-1:0]  resets_done;
   logic                          link_up;
   logic                          link_dead;
   logic                          slow_mode;      // later recovery limit in force
   logic [mls_pkg::FLAGS_W-1:0]   alert_bits;
   logic [mls_pkg::LIMIT_W-1:0]   fixless_count;

   mls_pkg::item_type   pending_words[$];          // words waiting for the driver
   mls_pkg::result_type expected_results[$];      // predictions waiting for the DUT

   int  queued_total;
   int  accepted_total;
   int  results_seen;
   int  errors;
   bit  req_took;        // word accepted at the last rising edge
   bit  gaps_on;         // random idling enabled
   bit  hold_req;        // ask receiver for a long hold-off
   int  send_gap;
   int  stall_left;
   int  hold_left;

   // ---------------------------------------------------------------------
   // Clock
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Safety net: far beyond the slowest legal run (~1750 words, each with
   // worst gaps and stalls, one long hold-off).
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Predictor: one word in, one result out, state updated in place.
   // ---------------------------------------------------------------------
   function automatic mls_pkg::result_type supervise(input mls_pkg::item_type w);
      mls_pkg::result_type          r;
      logic [mls_pkg::LIMIT_W-1:0]  lim;
      r = '0;
      r.alert_code = mls_pkg::ALERT_NONE;
      if (w.opcode != mls_pkg::OP_TICK) begin
         // any frame clears the idle count
         idle_ticks = '0;
         if (w.opcode == mls_pkg::OP_STATUS) begin
            alert_bits[mls_pkg::LFLAGS_W-1:0] = w.link_flags;
            // extra flags only loaded when the marker was present
            if (w.extra_valid)
               alert_bits[mls_pkg::FLAGS_W-1:mls_pkg::LFLAGS_W] = w.extra_flags;
         end
         if (w.opcode == mls_pkg::OP_STATUS || w.opcode == mls_pkg::OP_HEADED) begin
            link_up   = 1'b1;
            link_dead = 1'b0;
         end
      end else begin
         if (idle_ticks != mls_pkg::LIMIT_MAX) idle_ticks = idle_ticks + 1'b1;
         if (!link_dead && link_up) begin
            // ready and healthy: normal limit, resets can declare a crash
            if (idle_ticks >= cfg_now.ready_idle_limit) begin
               idle_ticks = '0;
               r.modem_reset = 1'b1;
               if (resets_done != mls_pkg::RCOUNT_MAX) resets_done = resets_done + 1'b1;
               if (resets_done > cfg_now.crash_reset_count) link_dead = 1'b1;
               alert_bits = '0;
            end
         end else begin
            // recovery: first limit until one reset, then the slower one
            lim = slow_mode ? cfg_now.recovery_later_limit
                            : cfg_now.recovery_first_limit;
            if (idle_ticks >= lim) begin
               slow_mode = 1'b1;
               idle_ticks = '0;
               r.modem_reset = 1'b1;
               if (resets_done != mls_pkg::RCOUNT_MAX) resets_done = resets_done + 1'b1;
               alert_bits = '0;
            end
         end
         if (idle_ticks > cfg_now.stale_limit) alert_bits = '0;
      end

      if (alert_bits[mls_pkg::FLAG_FIX]) begin
         if (alert_bits[mls_pkg::FLAG_SPEED])           r.alert_code = mls_pkg::ALERT_SPEED;
         else if (alert_bits[mls_pkg::FLAG_WEEK])       r.alert_code = mls_pkg::ALERT_WEEK;
         else if (alert_bits[mls_pkg::FLAG_DAY])        r.alert_code = mls_pkg::ALERT_DAY;
         else if (alert_bits[mls_pkg::FLAG_CONTINUOUS])
            r.alert_code = mls_pkg::ALERT_CONTINUOUS;
         else if (alert_bits[mls_pkg::FLAG_MOVING_OUT])
            r.alert_code = mls_pkg::ALERT_MOVING_OUT;
         fixless_count = '0;
      end else if (w.low_power) begin
         if (fixless_count != mls_pkg::LIMIT_MAX) fixless_count = fixless_count + 1'b1;
         if (fixless_count >= cfg_now.no_fix_limit) begin
            fixless_count = '0;
            r.power_off = 1'b1;
         end
      end
      r.crashed     = link_dead;
      r.reset_total = resets_done;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      if (errors <= MAX_PRINTS)
         $display("ERROR %0t ns result %0d %s: got %0d, want %0d",
                  $time, results_seen, what, got, want);
   endtask

   // ---------------------------------------------------------------------
   // Monitor: check results first, then predict any word taken this edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      mls_pkg::result_type want;
      mls_pkg::item_type   w;
      req_took <= !reset && req_chan.valid && req_chan.ready;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result word with nothing pending", 1, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_chan.modem_reset !== want.modem_reset)
                  report_mismatch("modem_reset", rsp_chan.modem_reset, want.modem_reset);
               if (rsp_chan.crashed !== want.crashed)
                  report_mismatch("crashed", rsp_chan.crashed, want.crashed);
               if (rsp_chan.alert_code !== want.alert_code)
                  report_mismatch("alert_code", rsp_chan.alert_code, want.alert_code);
               if (rsp_chan.power_off !== want.power_off)
                  report_mismatch("power_off", rsp_chan.power_off, want.power_off);
               if (rsp_chan.reset_total !== want.reset_total)
                  report_mismatch("reset_total", rsp_chan.reset_total, want.reset_total);
            end
            results_seen++;
         end
         if (req_chan.valid && req_chan.ready) begin
            w.opcode      = req_chan.opcode;
            w.link_flags  = req_chan.link_flags;
            w.extra_flags = req_chan.extra_flags;
            w.extra_valid = req_chan.extra_valid;
            w.low_power   = req_chan.low_power;
            expected_results.push_back(supervise(w));
            accepted_total++;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Driver: new word only once the current one is taken; gaps between words.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      mls_pkg::item_type w;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_took) begin
         if (send_gap > 0) begin
            send_gap--;
            req_chan.valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            if (gaps_on && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 6);   // random burst of idle cycles
               req_chan.valid <= 1'b0;
            end else begin
               w = pending_words.pop_front();
               req_chan.valid       <= 1'b1;
               req_chan.opcode      <= w.opcode;
               req_chan.link_flags  <= w.link_flags;
               req_chan.extra_flags <= w.extra_flags;
               req_chan.extra_valid <= w.extra_valid;
               req_chan.low_power   <= w.low_power;
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random stall bursts, plus one long counted hold-off on request.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (hold_req) begin
         hold_req  = 1'b0;
         hold_left = HOLD_CYCLES - 1;
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 6);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_word(input logic [mls_pkg::OPCODE_W-1:0] op,
                             input logic [mls_pkg::LFLAGS_W-1:0] lf,
                             input logic [mls_pkg::XFLAGS_W-1:0] xf,
                             input logic xv, input logic ps);
      mls_pkg::item_type w;
      w.opcode      = op;
      w.link_flags  = lf;
      w.extra_flags = xf;
      w.extra_valid = xv;
      w.low_power   = ps;
      pending_words.push_back(w);
      queued_total++;
   endtask

   task automatic queue_random(input logic [mls_pkg::OPCODE_W-1:0] op);
      queue_word(op, mls_pkg::LFLAGS_W'($urandom_range(0, 63)),
                 mls_pkg::XFLAGS_W'($urandom_range(0, 15)),
                 1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0);
   endtask

   // Mostly sessions: a status or headed frame that brings the link up, then a
   // run of up to max_run idle ticks. The rest is loose noise.
   task automatic random_traffic(input int count, input int max_run);
      int left;
      int run;
      logic [mls_pkg::OPCODE_W-1:0] op;
      left = count;
      while (left > 0) begin
         if ($urandom_range(0, 9) < 7) begin
            queue_random($urandom_range(0, 1) ? mls_pkg::OP_STATUS : mls_pkg::OP_HEADED);
            left--;
            run = $urandom_range(0, max_run);
            while (run > 0 && left > 0) begin
               queue_random(mls_pkg::OP_TICK);
               run--;
               left--;
            end
         end else begin
            op = mls_pkg::OPCODE_W'($urandom_range(0, 3));
            queue_random(op);
            left--;
         end
      end
   endtask

   task automatic wait_drained();
      while (accepted_total != queued_total || expected_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(input logic [mls_pkg::CSR_IDX_W-1:0] idx,
                            input logic [mls_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         mls_pkg::CSR_READY_IDLE_LIMIT:     cfg_now.ready_idle_limit     = data;
         mls_pkg::CSR_RECOVERY_FIRST_LIMIT: cfg_now.recovery_first_limit = data;
         mls_pkg::CSR_RECOVERY_LATER_LIMIT: cfg_now.recovery_later_limit = data;
         mls_pkg::CSR_CRASH_RESET_COUNT:
            cfg_now.crash_reset_count = data[mls_pkg::RCOUNT_W-1:0];
         mls_pkg::CSR_STALE_LIMIT:          cfg_now.stale_limit          = data;
         mls_pkg::CSR_NO_FIX_LIMIT:         cfg_now.no_fix_limit         = data;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Only called with the pipe empty.
   task automatic configure(input int ready_lim, input int first_lim, input int later_lim,
                            input int crash_cnt, input int stale_lim, input int nofix_lim);
      wait_drained();
      write_reg(mls_pkg::CSR_READY_IDLE_LIMIT,     mls_pkg::CSR_DATA_W'(ready_lim));
      write_reg(mls_pkg::CSR_RECOVERY_FIRST_LIMIT, mls_pkg::CSR_DATA_W'(first_lim));
      write_reg(mls_pkg::CSR_RECOVERY_LATER_LIMIT, mls_pkg::CSR_DATA_W'(later_lim));
      write_reg(mls_pkg::CSR_CRASH_RESET_COUNT,    mls_pkg::CSR_DATA_W'(crash_cnt));
      write_reg(mls_pkg::CSR_STALE_LIMIT,          mls_pkg::CSR_DATA_W'(stale_lim));
      write_reg(mls_pkg::CSR_NO_FIX_LIMIT,         mls_pkg::CSR_DATA_W'(nofix_lim));
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      int k;
      // everything known from time zero
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_index = mls_pkg::CSR_READY_IDLE_LIMIT;
      csr_wdata = '0;
      req_chan.valid       = 1'b0;
      req_chan.opcode      = mls_pkg::OP_STATUS;
      req_chan.link_flags  = '0;
      req_chan.extra_flags = '0;
      req_chan.extra_valid = 1'b0;
      req_chan.low_power   = 1'b0;
      rsp_chan.ready       = 1'b0;
      req_took = 1'b0;
      gaps_on  = 1'b1;
      hold_req = 1'b0;
      send_gap = 0;
      stall_left = 0;
      hold_left  = 0;
      queued_total = 0;
      accepted_total = 0;
      results_seen = 0;
      errors = 0;

      cfg_now.ready_idle_limit     = mls_pkg::RST_READY_IDLE_LIMIT;
      cfg_now.recovery_first_limit = mls_pkg::RST_RECOVERY_FIRST_LIMIT;
      cfg_now.recovery_later_limit = mls_pkg::RST_RECOVERY_LATER_LIMIT;
      cfg_now.crash_reset_count    = mls_pkg::RST_CRASH_RESET_COUNT;
      cfg_now.stale_limit          = mls_pkg::RST_STALE_LIMIT;
      cfg_now.no_fix_limit         = mls_pkg::RST_NO_FIX_LIMIT;
      idle_ticks    = '0;
      resets_done   = '0;
      link_up       = 1'b0;
      link_dead     = 1'b0;
      slow_mode     = 1'b0;
      alert_bits    = '0;
      fixless_count = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, reset register values.
      queue_word(mls_pkg::OP_STATUS,   6'h00, 4'h0, 1'b1, 1'b0);
      queue_word(mls_pkg::OP_STATUS,   6'h3F, 4'hF, 1'b1, 1'b1);  // everything set: speed wins
      queue_word(mls_pkg::OP_STATUS,   6'h01, 4'h2, 1'b1, 1'b0);  // week
      queue_word(mls_pkg::OP_STATUS,   6'h01, 4'h3, 1'b1, 1'b0);  // week over day
      queue_word(mls_pkg::OP_STATUS,   6'h01, 4'h1, 1'b1, 1'b0);  // day
      queue_word(mls_pkg::OP_STATUS,   6'h21, 4'h0, 1'b1, 1'b0);  // continuous drive
      queue_word(mls_pkg::OP_STATUS,   6'h01, 4'h8, 1'b1, 1'b0);  // moving while logged out
      queue_word(mls_pkg::OP_STATUS,   6'h01, 4'h0, 1'b0, 1'b0);  // no marker: extras kept
      queue_word(mls_pkg::OP_STATUS,   6'h01, 4'hF, 1'b0, 1'b1);
      queue_word(mls_pkg::OP_HEADED,   6'h3F, 4'hF, 1'b1, 1'b1);  // payload ignored
      queue_word(mls_pkg::OP_UNHEADED, 6'h3F, 4'hF, 1'b1, 1'b1);
      queue_word(mls_pkg::OP_STATUS,   6'h3E, 4'hF, 1'b1, 1'b0);  // no fix: no alert
      queue_word(mls_pkg::OP_STATUS,   6'h00, 4'h0, 1'b0, 1'b1);  // no fix in power save
      queue_word(mls_pkg::OP_STATUS,   6'h11, 4'h0, 1'b1, 1'b0);
      // idle long enough for the stored flags to go stale
      for (k = 0; k < 12; k++) queue_word(mls_pkg::OP_TICK, 6'h00, 4'h0, 1'b0, 1'b0);

      // Small limits; receiver holds off at the start while the sender keeps
      // offering, so the input side must back up.
      configure(4, 3, 6, 2, 2, 5);
      hold_req = 1'b1;
      random_traffic(400, 12);

      // Zero limits: every tick resets, every fixless power-save word powers off.
      configure(0, 0, 0, 0, 0, 0);
      random_traffic(150, 3);

      // Largest limits.
      configure(65535, 65535, 65535, 255, 65535, 65535);
      random_traffic(150, 20);

      // A spread of small random settings, one of them without idling.
      for (k = 0; k < 4; k++) begin
         configure($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 20),
                   $urandom_range(0, 8), $urandom_range(0, 15), $urandom_range(1, 10));
         gaps_on = (k != 2);
         random_traffic(120, 25);
      end
      gaps_on = 1'b1;

      // Reset count saturation: each tick resets, crash threshold at its top.
      configure(1, 1, 1, 255, 0, 1);
      queue_word(mls_pkg::OP_STATUS, 6'h01, 4'h0, 1'b1, 1'b1);
      for (k = 0; k < 300; k++) queue_random(mls_pkg::OP_TICK);

      // Last stretch runs flat out on both sides.
      configure($urandom_range(1, 10), $urandom_range(1, 10), $urandom_range(1, 15),
                $urandom_range(0, 6), $urandom_range(0, 12), $urandom_range(1, 8));
      gaps_on = 1'b0;
      random_traffic(250, 25);

      wait_drained();
      repeat (8) @(negedge clock);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/mls_pkg.sv
src/mls_if.sv
src/mls_csr.sv
src/mls_eval.sv
src/modem_link_supervisor.sv
sim/tb_modem_link_supervisor.sv
